// ===== rtl/core/mqfb_pkg.sv =====
`default_nettype none

package mqfb_pkg;

	// Bank geometry
	localparam int NUM_QUEUES  = 4;
	localparam int QUEUE_DEPTH = 16;
	localparam int ITEM_WIDTH  = 32;

	localparam int QIDX_W      = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int ENTRY_DEPTH = NUM_QUEUES * QUEUE_DEPTH;
	localparam int ENTRY_AW    = $clog2(ENTRY_DEPTH);

	// Fixed field widths of the channels and registers
	localparam int QSEL_W       = 3;
	localparam int VALUE_W      = 32;
	localparam int STATUS_W     = 2;
	localparam int TOTAL_W      = 7;
	localparam int CAP_W        = 5;
	localparam int NUM_CAP_REGS = 4;
	localparam int CFG_IDX_W    = 2;

	typedef logic [QIDX_W-1:0]     qid_t;
	typedef logic [QSEL_W-1:0]     qsel_t;
	typedef logic [PTR_W-1:0]      ptr_t;
	typedef logic [FILL_W-1:0]     fill_t;
	typedef logic [ENTRY_AW-1:0]   addr_t;
	typedef logic [ITEM_WIDTH-1:0] item_t;
	typedef logic [VALUE_W-1:0]    value_t;
	typedef logic [STATUS_W-1:0]   status_t;
	typedef logic [TOTAL_W-1:0]    total_t;
	typedef logic [CAP_W-1:0]      cap_t;
	typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;

	localparam cap_t CAP_RESET = 5'd16;

	// Operation codes
	localparam logic MODE_PUSH = 1'b0;
	localparam logic MODE_POP  = 1'b1;

	// Result status codes
	localparam status_t ST_OK        = 2'd0;
	localparam status_t ST_BAD_INDEX = 2'd1;
	localparam status_t ST_FULL      = 2'd2;
	localparam status_t ST_EMPTY     = 2'd3;

	// Per-queue control word held in the control memory
	typedef struct packed {
		ptr_t  head;
		ptr_t  tail;
		fill_t fill;
	} ctl_word_t;

	typedef struct packed {
		logic      en;
		qid_t      addr;
		ctl_word_t data;
	} ctl_wr_t;

	typedef struct packed {
		logic  wr;
		logic  rd;
		addr_t addr;
		item_t wdata;
	} entry_req_t;

	// Pointer step with wrap at the queue's capacity
	function automatic ptr_t ptr_advance(ptr_t p, fill_t cap);
		fill_t nxt;
		nxt = fill_t'(p) + fill_t'(1);
		return (nxt >= cap) ? ptr_t'(0) : ptr_t'(nxt);
	endfunction

	// Register value clamped to 1..QUEUE_DEPTH
	function automatic fill_t clamp_cap(cap_t c);
		fill_t r;
		if (c == '0) begin
			r = fill_t'(1);
		end else if (int'(c) > QUEUE_DEPTH) begin
			r = fill_t'(QUEUE_DEPTH);
		end else begin
			r = fill_t'(c);
		end
		return r;
	endfunction

	// Storage slot of a queue entry
	function automatic addr_t slot_addr(qid_t q, ptr_t p);
		return addr_t'(q) * addr_t'(QUEUE_DEPTH) + addr_t'(p);
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/mqfb_ifs.sv =====
`default_nettype none

// Command channel: one push or pop per transfer
interface mqfb_cmd_if;
	logic                 valid;
	logic                 ready;
	logic                 mode;
	mqfb_pkg::qsel_t      queue_index;
	mqfb_pkg::value_t     item_value;

	modport source (output valid, output mode, output queue_index, output item_value,
		input ready);
	modport sink (input valid, input mode, input queue_index, input item_value,
		output ready);
endinterface

// Response channel: one result per command
interface mqfb_rsp_if;
	logic                 valid;
	logic                 ready;
	mqfb_pkg::status_t    status;
	mqfb_pkg::value_t     popped_value;
	mqfb_pkg::total_t     total_count;

	modport source (output valid, output status, output popped_value, output total_count,
		input ready);
	modport sink (input valid, input status, input popped_value, input total_count,
		output ready);
endinterface

`default_nettype wire

// ===== rtl/core/mqfb_cfg.sv =====
`default_nettype none

module mqfb_cfg (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     cfg_we,
	input  mqfb_pkg::cfg_idx_t      cfg_index,
	input  mqfb_pkg::cap_t          cfg_data,
	output mqfb_pkg::fill_t         eff_cap [mqfb_pkg::NUM_QUEUES]
);

	mqfb_pkg::cap_t cap_q [mqfb_pkg::NUM_CAP_REGS];

	// Capacity registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < mqfb_pkg::NUM_CAP_REGS; i++) begin
				cap_q[i] <= mqfb_pkg::CAP_RESET;
			end
		end else if (cfg_we) begin
			cap_q[cfg_index] <= cfg_data;
		end
	end

	// Effective capacity; queues without a register use the full depth
	for (genvar g = 0; g < mqfb_pkg::NUM_QUEUES; g++) begin : g_cap
		if (g < mqfb_pkg::NUM_CAP_REGS) begin : g_reg
			assign eff_cap[g] = mqfb_pkg::clamp_cap(cap_q[g]);
		end else begin : g_full
			assign eff_cap[g] = mqfb_pkg::fill_t'(mqfb_pkg::QUEUE_DEPTH);
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/mqfb_ctl_ram.sv =====
`default_nettype none

module mqfb_ctl_ram (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     rd_en,
	input  mqfb_pkg::qid_t          rd_addr,
	input  mqfb_pkg::ctl_wr_t       wr,
	output mqfb_pkg::ctl_word_t     rd_data
);

	mqfb_pkg::ctl_word_t mem [mqfb_pkg::NUM_QUEUES];
	mqfb_pkg::ctl_word_t rd_word_q;
	logic [mqfb_pkg::NUM_QUEUES-1:0] vld_q;
	logic                            rd_vld_q;

	// Control words, synchronous read
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_word_q <= mem[rd_addr];
		end
	end

	// Written flags: an unwritten word reads as all zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr.en) begin
				vld_q[wr.addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_word_q : '0;

endmodule

`default_nettype wire

// ===== rtl/core/mqfb_entry_ram.sv =====
`default_nettype none

module mqfb_entry_ram (
	input  wire                     clk,
	input  mqfb_pkg::entry_req_t    req,
	output mqfb_pkg::item_t         rd_data
);

	mqfb_pkg::item_t mem [mqfb_pkg::ENTRY_DEPTH];
	mqfb_pkg::item_t rd_q;

	// Single port: push writes, pop reads
	always_ff @(posedge clk) begin
		if (req.wr) begin
			mem[req.addr] <= req.wdata;
		end
		if (req.rd) begin
			rd_q <= mem[req.addr];
		end
	end

	assign rd_data = rd_q;

endmodule

`default_nettype wire

// ===== rtl/core/multi_queue_fifo_bank.sv =====
// Bank of independent circular FIFOs sharing one entry memory.
// cmd channel: valid/ready; each transfer is a push (mode 0) of item_value
//   or a pop (mode 1) on queue queue_index.
// rsp channel: valid/ready; one result per command with status (ok, bad
//   index, full, empty), popped_value (zero unless a pop succeeded) and
//   total_count, the entries held across all queues after the command.
// Config port: cfg_we writes cfg_data into capacity register cfg_index
//   (queues 0..3); write only while the bank is idle. Zero acts as one.
// Flow: an accepted command passes stage 1 (control word read), stage 2
//   (entry access) and the output register. No new command is taken until
//   the read-modify-write of the queue control word (read, then update) ends.
// Reset: all queues empty, pointers zero, capacities 16. No clearing pass.
// Stall: while rsp is stalled one more command is accepted and held after
//   its memory access; ready then stays low until the result is taken.
`default_nettype none

module multi_queue_fifo_bank (
	input  wire                     clk,
	input  wire                     arst_n,
	mqfb_cmd_if.sink                cmd,
	mqfb_rsp_if.source              rsp,
	input  wire                     cfg_we,
	input  mqfb_pkg::cfg_idx_t      cfg_index,
	input  mqfb_pkg::cap_t          cfg_data
);

	mqfb_pkg::fill_t     eff_cap [mqfb_pkg::NUM_QUEUES];
	mqfb_pkg::ctl_word_t ctl_rd;
	mqfb_pkg::ctl_word_t ctl_nxt;
	mqfb_pkg::ctl_wr_t   ctl_wr;
	mqfb_pkg::entry_req_t ent_req;
	mqfb_pkg::item_t     ent_rd;

	logic                cmd_take;
	logic                s2_move;

	// Stage 1: control word read in flight
	logic                valid_s1;
	logic                mode_s1;
	mqfb_pkg::qsel_t     qsel_s1;
	mqfb_pkg::value_t    value_s1;

	// Stage 2: entry read in flight
	logic                valid_s2;
	mqfb_pkg::status_t   status_s2;
	logic                pop_ok_s2;
	mqfb_pkg::total_t    total_s2;

	// Output register
	logic                rsp_valid_q;
	mqfb_pkg::status_t   rsp_status_q;
	mqfb_pkg::value_t    rsp_popped_q;
	mqfb_pkg::total_t    rsp_total_q;

	mqfb_pkg::total_t    total_q;
	mqfb_pkg::total_t    total_nxt;

	mqfb_pkg::qid_t      q_s1;
	mqfb_pkg::fill_t     cap_s1;
	logic                bad_s1;
	logic                push_ok;
	logic                pop_ok;
	mqfb_pkg::status_t   status_nxt;

	mqfb_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.eff_cap   (eff_cap)
	);

	mqfb_ctl_ram u_ctl_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (cmd_take),
		.rd_addr (cmd.queue_index[mqfb_pkg::QIDX_W-1:0]),
		.wr      (ctl_wr),
		.rd_data (ctl_rd)
	);

	mqfb_entry_ram u_entry_ram (
		.clk     (clk),
		.req     (ent_req),
		.rd_data (ent_rd)
	);

	// Handshake: one command in flight ahead of the result slot
	assign s2_move   = valid_s2 && (!rsp_valid_q || rsp.ready);
	assign cmd.ready = !valid_s1 && (!valid_s2 || s2_move);
	assign cmd_take  = cmd.valid && cmd.ready;

	// Stage 1 decision on the fetched control word
	assign q_s1   = qsel_s1[mqfb_pkg::QIDX_W-1:0];
	assign bad_s1 = int'(qsel_s1) >= mqfb_pkg::NUM_QUEUES;
	assign cap_s1 = eff_cap[q_s1];

	always_comb begin
		ctl_nxt    = ctl_rd;
		status_nxt = mqfb_pkg::ST_OK;
		push_ok    = 1'b0;
		pop_ok     = 1'b0;
		if (bad_s1) begin
			status_nxt = mqfb_pkg::ST_BAD_INDEX;
		end else if (mode_s1 == mqfb_pkg::MODE_PUSH) begin
			if (ctl_rd.fill >= cap_s1) begin
				status_nxt = mqfb_pkg::ST_FULL;
			end else begin
				push_ok      = 1'b1;
				ctl_nxt.tail = mqfb_pkg::ptr_advance(ctl_rd.tail, cap_s1);
				ctl_nxt.fill = ctl_rd.fill + mqfb_pkg::fill_t'(1);
			end
		end else begin
			if (ctl_rd.fill == '0) begin
				status_nxt = mqfb_pkg::ST_EMPTY;
			end else begin
				pop_ok       = 1'b1;
				ctl_nxt.head = mqfb_pkg::ptr_advance(ctl_rd.head, cap_s1);
				ctl_nxt.fill = ctl_rd.fill - mqfb_pkg::fill_t'(1);
			end
		end
	end

	always_comb begin
		total_nxt = total_q;
		if (push_ok) begin
			total_nxt = total_q + mqfb_pkg::total_t'(1);
		end else if (pop_ok) begin
			total_nxt = total_q - mqfb_pkg::total_t'(1);
		end
	end

	// Write-back of the control word and the entry access
	assign ctl_wr.en   = valid_s1 && (push_ok || pop_ok);
	assign ctl_wr.addr = q_s1;
	assign ctl_wr.data = ctl_nxt;

	assign ent_req.wr    = valid_s1 && push_ok;
	assign ent_req.rd    = valid_s1 && pop_ok;
	assign ent_req.addr  = mqfb_pkg::slot_addr(q_s1, push_ok ? ctl_rd.tail : ctl_rd.head);
	assign ent_req.wdata = mqfb_pkg::item_t'(value_s1);

	// Pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			rsp_valid_q <= 1'b0;
			total_q     <= '0;
		end else begin
			valid_s1 <= cmd_take;
			if (valid_s1) begin
				valid_s2 <= 1'b1;
				total_q  <= total_nxt;
			end else if (s2_move) begin
				valid_s2 <= 1'b0;
			end
			if (s2_move) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Pipeline payload
	always_ff @(posedge clk) begin
		if (cmd_take) begin
			mode_s1  <= cmd.mode;
			qsel_s1  <= cmd.queue_index;
			value_s1 <= cmd.item_value;
		end
		if (valid_s1) begin
			status_s2 <= status_nxt;
			pop_ok_s2 <= pop_ok;
			total_s2  <= total_nxt;
		end
		if (s2_move) begin
			rsp_status_q <= status_s2;
			rsp_popped_q <= pop_ok_s2 ? mqfb_pkg::value_t'(ent_rd) : '0;
			rsp_total_q  <= total_s2;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = rsp_status_q;
	assign rsp.popped_value = rsp_popped_q;
	assign rsp.total_count  = rsp_total_q;

	// Only one command between acceptance and the result slot
	a_single_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		!(valid_s1 && valid_s2))
		else $error("two commands in flight");

	// Total never exceeds the bank size
	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(total_q) <= mqfb_pkg::ENTRY_DEPTH)
		else $error("total count above bank size");

	// A successful push raises the total by one
	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && push_ok |=> total_q == mqfb_pkg::total_t'($past(total_q) + 1'b1))
		else $error("push did not bump total");

	// Failed commands return no data
	a_no_data_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_status_q != mqfb_pkg::ST_OK |-> rsp_popped_q == '0)
		else $error("data on a failed command");

endmodule

`default_nettype wire
